[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked while reset is low
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[src/ccdr_pkg.sv]
package ccdr_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int DUTY_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int LEVEL_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_CURRENT_LIMIT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_CEILING  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUTY_FLOOR    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAIT_INITIAL  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAIT_SETTLED  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FULL_CONFIRM  = 3'd5;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_CURRENT_LIMIT = 12'd33;
   localparam logic [DUTY_W-1:0]   RST_DUTY_CEILING  = 8'd60;
   localparam logic [DUTY_W-1:0]   RST_DUTY_FLOOR    = 8'd2;
   localparam logic [COUNT_W-1:0]  RST_WAIT_INITIAL  = 8'd20;
   localparam logic [COUNT_W-1:0]  RST_WAIT_SETTLED  = 8'd250;
   localparam logic [COUNT_W-1:0]  RST_FULL_CONFIRM  = 8'd200;

   localparam logic [LEVEL_W-1:0] LEVEL_NEAR_FULL = 7'd99;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] current_limit;
      logic [DUTY_W-1:0]   duty_ceiling;
      logic [DUTY_W-1:0]   duty_floor;
      logic [COUNT_W-1:0]  wait_initial;
      logic [COUNT_W-1:0]  wait_settled;
      logic [COUNT_W-1:0]  full_confirm_ticks;
   } ccdr_cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0]   target_duty;
      logic [DUTY_W-1:0]   ramp_duty;
      logic [COUNT_W-1:0]  high_count;
      logic [COUNT_W-1:0]  low_count;
      logic [SAMPLE_W-1:0] low_threshold;
      logic [COUNT_W-1:0]  wait_limit;
   } ccdr_loop_type;

endpackage

[src/ccdr_regulate.sv]
module ccdr_regulate (
   input  ccdr_pkg::ccdr_cfg_type          cfg,
   input  ccdr_pkg::ccdr_loop_type         cur,
   input  logic [ccdr_pkg::SAMPLE_W-1:0]   sample,
   output ccdr_pkg::ccdr_loop_type         nxt
);
   import ccdr_pkg::*;

   logic [COUNT_W-1:0] high_inc;
   logic [COUNT_W-1:0] low_inc;

   assign high_inc = cur.high_count + COUNT_W'(1);
   assign low_inc  = cur.low_count + COUNT_W'(1);

   always_comb begin
      nxt = cur;
      priority if (sample > cfg.current_limit) begin
         nxt.low_count = '0;
         if (high_inc > cur.wait_limit) begin
            if (cur.target_duty > cfg.duty_floor) begin
               nxt.target_duty = cur.target_duty - DUTY_W'(1);
            end
            nxt.high_count    = '0;
            nxt.low_threshold = (cfg.current_limit != '0) ?
                                cfg.current_limit - SAMPLE_W'(1) : '0;
            nxt.wait_limit    = cfg.wait_settled;
         end else begin
            nxt.high_count = high_inc;
         end
      end else if (sample < cur.low_threshold) begin
         nxt.high_count = '0;
         if (low_inc > cur.wait_limit) begin
            if (cur.target_duty < cfg.duty_ceiling) begin
               nxt.target_duty = cur.target_duty + DUTY_W'(1);
            end
            nxt.low_count = '0;
         end else begin
            nxt.low_count = low_inc;
         end
      end else begin
         nxt.high_count = '0;
         nxt.low_count  = '0;
      end
      // ramp follows the updated target
      if (cur.ramp_duty < nxt.target_duty) begin
         nxt.ramp_duty = cur.ramp_duty + DUTY_W'(1);
      end else begin
         nxt.ramp_duty = nxt.target_duty;
      end
   end

endmodule

[src/charge_current_duty_regulator.sv]
// a result is valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle while rsp_tready is high, with a one-deep result register
// req_tready stays high while the result register is empty or being drained
// reset (synchronous, active high) loads the register defaults, clears the
// regulator state and empties the result register
`include "assert_macros.svh"

module charge_current_duty_regulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ccdr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ccdr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // charger_connected, current_sample[12], battery_level[7],
   // shown_level_full, regulate_window, zero pad[2]
   input  logic [ccdr_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pwm_on, pwm_duty[8], ramped_duty[8], battery_full, zero pad[6]
   output logic [ccdr_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ccdr_pkg::*;

   ccdr_cfg_type       cfg_ff;
   ccdr_loop_type      loop_ff;
   ccdr_loop_type      loop_in;
   ccdr_loop_type      loop_reg;
   logic [COUNT_W-1:0] full_count_ff;
   logic [COUNT_W-1:0] full_count_in;
   logic [COUNT_W-1:0] full_count_sat;
   logic               full_flag_ff;
   logic               full_flag_in;
   logic               pwm_running_ff;
   logic               pwm_running_in;
   logic [DUTY_W-1:0]  duty_out;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic               req_accept;

   logic               charger;
   logic [SAMPLE_W-1:0] sample;
   logic [LEVEL_W-1:0] level;
   logic               shown_full;
   logic               window;

   assign charger    = req_tdata[0];
   assign sample     = req_tdata[SAMPLE_W:1];
   assign level      = req_tdata[SAMPLE_W+LEVEL_W:SAMPLE_W+1];
   assign shown_full = req_tdata[SAMPLE_W+LEVEL_W+1];
   assign window     = req_tdata[SAMPLE_W+LEVEL_W+2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ccdr_regulate u_regulate (
      .cfg    (cfg_ff),
      .cur    (loop_ff),
      .sample (sample),
      .nxt    (loop_reg)
   );

   assign full_count_sat = (full_count_ff != COUNT_MAX) ?
                           full_count_ff + COUNT_W'(1) : full_count_ff;

   always_comb begin
      loop_in        = loop_ff;
      full_count_in  = full_count_ff;
      full_flag_in   = full_flag_ff;
      pwm_running_in = pwm_running_ff;
      duty_out       = '0;
      if (charger) begin
         if (level >= LEVEL_NEAR_FULL || full_flag_ff) begin
            if (shown_full && level >= LEVEL_FULL) begin
               full_count_in = full_count_sat;
               if (full_count_sat > cfg_ff.full_confirm_ticks) begin
                  pwm_running_in = 1'b0;
                  full_flag_in   = 1'b1;
               end
            end
         end else begin
            full_count_in  = '0;
            duty_out       = loop_ff.target_duty;
            pwm_running_in = 1'b1;
            if (window) begin
               loop_in = loop_reg;
            end
         end
      end else begin
         // charger removed: back to idle, ramp and step counters kept
         loop_in.wait_limit    = cfg_ff.wait_initial;
         loop_in.low_threshold = cfg_ff.current_limit;
         loop_in.target_duty   = '0;
         full_flag_in          = 1'b0;
         full_count_in         = '0;
         pwm_running_in        = 1'b0;
      end
      rsp_data_in = {(RSP_DATA_W - 2 - 2*DUTY_W)'(0), full_flag_in,
                     loop_in.ramp_duty, duty_out, pwm_running_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit      <= RST_CURRENT_LIMIT;
         cfg_ff.duty_ceiling       <= RST_DUTY_CEILING;
         cfg_ff.duty_floor         <= RST_DUTY_FLOOR;
         cfg_ff.wait_initial       <= RST_WAIT_INITIAL;
         cfg_ff.wait_settled       <= RST_WAIT_SETTLED;
         cfg_ff.full_confirm_ticks <= RST_FULL_CONFIRM;
         loop_ff.target_duty       <= '0;
         loop_ff.ramp_duty         <= '0;
         loop_ff.high_count        <= '0;
         loop_ff.low_count         <= '0;
         loop_ff.low_threshold     <= RST_CURRENT_LIMIT;
         loop_ff.wait_limit        <= RST_WAIT_INITIAL;
         full_count_ff             <= '0;
         full_flag_ff              <= 1'b0;
         pwm_running_ff            <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_CURRENT_LIMIT: cfg_ff.current_limit <= csr_wdata[SAMPLE_W-1:0];
               CSR_DUTY_CEILING:  cfg_ff.duty_ceiling  <= csr_wdata[DUTY_W-1:0];
               CSR_DUTY_FLOOR:    cfg_ff.duty_floor    <= csr_wdata[DUTY_W-1:0];
               CSR_WAIT_INITIAL:  cfg_ff.wait_initial  <= csr_wdata[COUNT_W-1:0];
               CSR_WAIT_SETTLED:  cfg_ff.wait_settled  <= csr_wdata[COUNT_W-1:0];
               CSR_FULL_CONFIRM:  cfg_ff.full_confirm_ticks <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            loop_ff        <= loop_in;
            full_count_ff  <= full_count_in;
            full_flag_ff   <= full_flag_in;
            pwm_running_ff <= pwm_running_in;
         end
         rsp_valid_ff <= req_accept || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_CLK(full_stops_pwm, clock, reset, full_flag_ff |-> !pwm_running_ff)
   `ASSERT_CLK(idle_clears_state, clock, reset, (req_accept && !charger) |=> (loop_ff.target_duty == '0 && !pwm_running_ff && !full_flag_ff))
   `ASSERT_CLK(duty_needs_pwm, clock, reset, (rsp_valid_ff && rsp_data_ff[DUTY_W:1] != '0) |-> rsp_data_ff[0])
   `ASSERT_ALWAYS(reset_empties_rsp, clock, reset |=> !rsp_valid_ff)

endmodule

[test/duty_regulator_checker.sv]
module duty_regulator_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ccdr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ccdr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ccdr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ccdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              outstanding,
   output int                              failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import ccdr_pkg::*;

   // same bit order as rsp_tdata, lowest field last
   typedef struct packed {
      logic              battery_full;
      logic [DUTY_W-1:0] ramped_duty;
      logic [DUTY_W-1:0] pwm_duty;
      logic              pwm_on;
   } tick_result_type;

   ccdr_cfg_type       regs;
   ccdr_loop_type      loop;
   logic [COUNT_W-1:0] full_count;
   logic               full_flag;
   logic               pwm_running;

   tick_result_type predicted_outputs[$];
   tick_result_type want;
   tick_result_type got;
   int              checked = 0;
   int              mismatches = 0;

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic tick_result_type advance_tick(input logic [REQ_DATA_W-1:0] data);
      logic                charger;
      logic                shown;
      logic                window;
      logic [SAMPLE_W-1:0] sample;
      logic [LEVEL_W-1:0]  level;
      tick_result_type     res;
      charger = data[0];
      sample  = data[12:1];
      level   = data[19:13];
      shown   = data[20];
      window  = data[21];
      res.pwm_duty = '0;
      if (charger) begin
         if (level >= LEVEL_NEAR_FULL || full_flag) begin
            if (shown && level >= LEVEL_FULL) begin
               if (full_count != COUNT_MAX) begin
                  full_count = full_count + COUNT_W'(1);
               end
               if (full_count > regs.full_confirm_ticks) begin
                  pwm_running = 1'b0;
                  full_flag   = 1'b1;
               end
            end
         end else begin
            full_count   = '0;
            res.pwm_duty = loop.target_duty;
            pwm_running  = 1'b1;
            if (window) begin
               if (sample <= regs.current_limit && sample >= loop.low_threshold) begin
                  loop.high_count = '0;
                  loop.low_count  = '0;
               end
               if (sample > regs.current_limit) begin
                  loop.high_count = loop.high_count + COUNT_W'(1);
                  if (loop.high_count > loop.wait_limit) begin
                     if (loop.target_duty > regs.duty_floor) begin
                        loop.target_duty = loop.target_duty - DUTY_W'(1);
                     end
                     loop.high_count    = '0;
                     loop.low_threshold = (regs.current_limit != '0) ?
                                          regs.current_limit - SAMPLE_W'(1) : '0;
                     loop.wait_limit    = regs.wait_settled;
                  end
                  loop.low_count = '0;
               end else if (sample < loop.low_threshold) begin
                  loop.low_count = loop.low_count + COUNT_W'(1);
                  if (loop.low_count > loop.wait_limit) begin
                     if (loop.target_duty < regs.duty_ceiling) begin
                        loop.target_duty = loop.target_duty + DUTY_W'(1);
                     end
                     loop.low_count = '0;
                  end
                  loop.high_count = '0;
               end
               if (loop.ramp_duty < loop.target_duty) begin
                  loop.ramp_duty = loop.ramp_duty + DUTY_W'(1);
               end else begin
                  loop.ramp_duty = loop.target_duty;
               end
            end
         end
      end else begin
         // unplugged: ramp and step counters keep their values
         loop.wait_limit    = regs.wait_initial;
         loop.low_threshold = regs.current_limit;
         loop.target_duty   = '0;
         full_flag          = 1'b0;
         full_count         = '0;
         pwm_running        = 1'b0;
      end
      res.pwm_on       = pwm_running;
      res.ramped_duty  = loop.ramp_duty;
      res.battery_full = full_flag;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs = '{current_limit: RST_CURRENT_LIMIT, duty_ceiling: RST_DUTY_CEILING,
                  duty_floor: RST_DUTY_FLOOR, wait_initial: RST_WAIT_INITIAL,
                  wait_settled: RST_WAIT_SETTLED, full_confirm_ticks: RST_FULL_CONFIRM};
         loop               = '0;
         loop.low_threshold = RST_CURRENT_LIMIT;
         loop.wait_limit    = RST_WAIT_INITIAL;
         full_count         = '0;
         full_flag          = 1'b0;
         pwm_running        = 1'b0;
         predicted_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CURRENT_LIMIT: regs.current_limit      = csr_wdata[SAMPLE_W-1:0];
               CSR_DUTY_CEILING:  regs.duty_ceiling       = csr_wdata[DUTY_W-1:0];
               CSR_DUTY_FLOOR:    regs.duty_floor         = csr_wdata[DUTY_W-1:0];
               CSR_WAIT_INITIAL:  regs.wait_initial       = csr_wdata[COUNT_W-1:0];
               CSR_WAIT_SETTLED:  regs.wait_settled       = csr_wdata[COUNT_W-1:0];
               CSR_FULL_CONFIRM:  regs.full_confirm_ticks = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(tick_result_type)-1:0];
            if (predicted_outputs.size() == 0) begin
               note_failure($sformatf("result %0d arrived with none expected", checked));
            end else begin
               want = predicted_outputs.pop_front();
               if (got.pwm_on !== want.pwm_on)
                  note_failure($sformatf("result %0d pwm_on expected %0d got %0d",
                                         checked, want.pwm_on, got.pwm_on));
               if (got.pwm_duty !== want.pwm_duty)
                  note_failure($sformatf("result %0d pwm_duty expected %0d got %0d",
                                         checked, want.pwm_duty, got.pwm_duty));
               if (got.ramped_duty !== want.ramped_duty)
                  note_failure($sformatf("result %0d ramped_duty expected %0d got %0d",
                                         checked, want.ramped_duty, got.ramped_duty));
               if (got.battery_full !== want.battery_full)
                  note_failure($sformatf("result %0d battery_full expected %0d got %0d",
                                         checked, want.battery_full, got.battery_full));
            end
            checked++;
         end
         if (req_tvalid && req_tready) begin
            predicted_outputs.push_back(advance_tick(req_tdata));
         end
      end
      outstanding <= predicted_outputs.size();
      failures    <= mismatches;
   end

endmodule

[test/tb_charge_current_duty_regulator.sv]
module tb_charge_current_duty_regulator;
   timeunit 1ns;
   timeprecision 1ps;
   import ccdr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;

   typedef enum int {BAND_HIGH, BAND_LOW, BAND_EDGE, BAND_ANY} sample_band_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // charger_connected, current_sample[12], battery_level[7],
   // shown_level_full, regulate_window, zero pad[2]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // pwm_on, pwm_duty[8], ramped_duty[8], battery_full, zero pad[6]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  hold_req = 1'b0;

   int           outstanding;
   int           failures;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   ccdr_cfg_type active_cfg;

   charge_current_duty_regulator u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   duty_regulator_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_tick(input logic charger, input logic [SAMPLE_W-1:0] sample,
                            input logic [LEVEL_W-1:0] level, input logic shown,
                            input logic window);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, window, shown, level, sample, charger};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_settings(input ccdr_cfg_type cfg);
      logic [CSR_ADDR_W-1:0] idx;
      logic [3:0]            junk;
      wait_for_drain();
      for (int i = 0; i < 8; i++) begin
         idx  = CSR_ADDR_W'(i);
         junk = 4'($urandom_range(15));
         csr_we   <= 1'b1;
         csr_addr <= idx;
         case (idx)
            CSR_CURRENT_LIMIT: csr_wdata <= cfg.current_limit;
            CSR_DUTY_CEILING:  csr_wdata <= {junk, cfg.duty_ceiling};
            CSR_DUTY_FLOOR:    csr_wdata <= {junk, cfg.duty_floor};
            CSR_WAIT_INITIAL:  csr_wdata <= {junk, cfg.wait_initial};
            CSR_WAIT_SETTLED:  csr_wdata <= {junk, cfg.wait_settled};
            CSR_FULL_CONFIRM:  csr_wdata <= {junk, cfg.full_confirm_ticks};
            default:           csr_wdata <= CSR_DATA_W'($urandom);
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active_cfg = cfg;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_band_type band);
      int lim;
      int pick;
      int offset;
      lim = int'(active_cfg.current_limit);
      case (band)
         BAND_HIGH: pick = (lim >= 4095) ? 4095 : int'($urandom_range(4095, lim + 1));
         BAND_LOW:  pick = (lim < 2) ? 0 : int'($urandom_range(lim - 2, 0));
         BAND_EDGE: begin
            offset = int'($urandom_range(2));
            pick = lim + offset - 1;
            if (pick < 0) pick = 0;
            if (pick > 4095) pick = 4095;
         end
         default:   pick = int'($urandom_range(4095));
      endcase
      return pick[SAMPLE_W-1:0];
   endfunction

   // charging sessions with random content, full-level runs and unplugged noise
   task automatic run_ticks(input int budget);
      int              kind;
      int              len;
      int              lim;
      sample_band_type band;
      logic [LEVEL_W-1:0] level;
      while (budget > 0) begin
         kind = int'($urandom_range(99));
         if (kind < 15) begin
            len = int'($urandom_range(4, 1));
         end else if (kind < 35) begin
            lim = int'(active_cfg.full_confirm_ticks);
            if (lim < 24 || $urandom_range(9) == 0) len = int'($urandom_range(lim + 6, 1));
            else len = int'($urandom_range(12, 1));
         end else begin
            len = int'($urandom_range(40, 5));
         end
         if (len > budget) len = budget;
         band = sample_band_type'($urandom_range(3));
         repeat (len) begin
            if (kind < 15) begin
               send_tick(1'b0, SAMPLE_W'($urandom_range(4095)),
                         LEVEL_W'($urandom_range(100)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (kind < 35) begin
               case ($urandom_range(7))
                  0:       level = LEVEL_NEAR_FULL;
                  1:       level = LEVEL_W'($urandom_range(98));
                  default: level = LEVEL_FULL;
               endcase
               send_tick(1'b1, SAMPLE_W'($urandom_range(4095)), level,
                         $urandom_range(4) != 0, 1'($urandom_range(1)));
            end else begin
               if ($urandom_range(9) == 0) band = sample_band_type'($urandom_range(3));
               send_tick(1'b1, pick_sample(band), LEVEL_W'($urandom_range(98)),
                         1'($urandom_range(1)), $urandom_range(9) != 0);
            end
         end
         budget -= len;
      end
   endtask

   task automatic sustained_ticks(input int n, input logic at_full);
      repeat (n) begin
         if (at_full) send_tick(1'b1, SAMPLE_W'($urandom_range(4095)), LEVEL_FULL, 1'b1,
                                1'($urandom_range(1)));
         else send_tick(1'b1, pick_sample(BAND_HIGH), LEVEL_W'($urandom_range(98)),
                        1'($urandom_range(1)), 1'b1);
      end
   endtask

   initial begin
      ccdr_cfg_type cfg;
      active_cfg = '{current_limit: RST_CURRENT_LIMIT, duty_ceiling: RST_DUTY_CEILING,
                     duty_floor: RST_DUTY_FLOOR, wait_initial: RST_WAIT_INITIAL,
                     wait_settled: RST_WAIT_SETTLED, full_confirm_ticks: RST_FULL_CONFIRM};
      send_idle_pct = 10;
      recv_idle_pct = 53;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, register defaults
      send_tick(1'b0, 12'd0, 7'd0, 1'b0, 1'b0);
      send_tick(1'b0, 12'd4095, LEVEL_FULL, 1'b1, 1'b1);
      send_tick(1'b1, 12'd0, 7'd0, 1'b0, 1'b1);
      send_tick(1'b1, 12'd4095, 7'd98, 1'b1, 1'b1);
      send_tick(1'b1, 12'd33, 7'd64, 1'b0, 1'b1);
      send_tick(1'b1, 12'd500, LEVEL_NEAR_FULL, 1'b0, 1'b1);
      send_tick(1'b1, 12'd500, LEVEL_FULL, 1'b1, 1'b1);
      send_tick(1'b1, 12'd500, LEVEL_NEAR_FULL, 1'b1, 1'b1);
      send_tick(1'b1, 12'd10, 7'd20, 1'b0, 1'b1);

      // directed, short waits: steps to ceiling, first reduction, floor, full
      cfg = '{current_limit: 12'd100, duty_ceiling: 8'd3, duty_floor: 8'd1,
              wait_initial: 8'd0, wait_settled: 8'd1, full_confirm_ticks: 8'd1};
      write_settings(cfg);
      repeat (4) send_tick(1'b1, 12'd10, 7'd50, 1'b0, 1'b1);
      send_tick(1'b1, 12'd4095, 7'd50, 1'b0, 1'b1);
      repeat (4) send_tick(1'b1, 12'd101, 7'd50, 1'b0, 1'b1);
      send_tick(1'b1, 12'd99, 7'd50, 1'b0, 1'b1);
      send_tick(1'b1, 12'd98, 7'd50, 1'b0, 1'b0);
      repeat (3) send_tick(1'b1, 12'd0, LEVEL_FULL, 1'b1, 1'b1);
      send_tick(1'b1, 12'd10, 7'd40, 1'b0, 1'b1);
      send_tick(1'b0, 12'd10, 7'd40, 1'b0, 1'b1);

      // back to power-on values
      cfg = '{current_limit: RST_CURRENT_LIMIT, duty_ceiling: RST_DUTY_CEILING,
              duty_floor: RST_DUTY_FLOOR, wait_initial: RST_WAIT_INITIAL,
              wait_settled: RST_WAIT_SETTLED, full_confirm_ticks: RST_FULL_CONFIRM};
      write_settings(cfg);
      run_ticks(150);

      cfg.current_limit      = SAMPLE_W'($urandom_range(400));
      cfg.duty_ceiling       = DUTY_W'($urandom_range(255));
      cfg.duty_floor         = DUTY_W'($urandom_range(40));
      cfg.wait_initial       = COUNT_W'($urandom_range(4));
      cfg.wait_settled       = COUNT_W'($urandom_range(8));
      cfg.full_confirm_ticks = COUNT_W'($urandom_range(6));
      write_settings(cfg);
      // long result stall while ticks keep coming
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      run_ticks(150);

      send_idle_pct = 53;
      recv_idle_pct = 10;
      cfg = '0;
      write_settings(cfg);
      run_ticks(100);

      cfg = '{current_limit: 12'd4095, duty_ceiling: 8'd255, duty_floor: 8'd255,
              wait_initial: 8'd255, wait_settled: 8'd255, full_confirm_ticks: 8'd254};
      write_settings(cfg);
      run_ticks(40);
      sustained_ticks(260, 1'b1);
      run_ticks(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      cfg.current_limit      = SAMPLE_W'($urandom_range(3000, 100));
      cfg.duty_ceiling       = 8'd255;
      cfg.duty_floor         = 8'd0;
      cfg.full_confirm_ticks = COUNT_W'($urandom_range(10));
      write_settings(cfg);
      send_tick(1'b0, 12'd0, 7'd0, 1'b0, 1'b0);
      // step counter wraps before it can pass the wait
      sustained_ticks(260, 1'b0);
      run_ticks(40);

      cfg.current_limit      = SAMPLE_W'($urandom_range(4095));
      cfg.duty_ceiling       = DUTY_W'($urandom_range(255));
      cfg.duty_floor         = DUTY_W'($urandom_range(255));
      cfg.wait_initial       = COUNT_W'($urandom_range(30));
      cfg.wait_settled       = COUNT_W'($urandom_range(60));
      cfg.full_confirm_ticks = COUNT_W'($urandom_range(20));
      write_settings(cfg);
      run_ticks(60);
      wait_for_drain();
      run_ticks(60);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
